// ----- hdl/uics_pkg.sv -----
// Shared types, byte constants and the ignorable code point table of the stripper.
`timescale 1ns / 1ps

package uics_pkg;

	localparam int unsigned CpW = 21;

	// lead bytes whose first trail byte has a narrowed range
	localparam logic [7:0] LeadE0 = 8'hE0;
	localparam logic [7:0] LeadED = 8'hED;
	localparam logic [7:0] LeadF0 = 8'hF0;
	localparam logic [7:0] LeadF4 = 8'hF4;

	localparam logic [7:0] TrailLo    = 8'h80;
	localparam logic [7:0] TrailHi    = 8'hBF;
	localparam logic [7:0] TrailLoE0  = 8'hA0;
	localparam logic [7:0] TrailHiED  = 8'h9F;
	localparam logic [7:0] TrailLoF0  = 8'h90;
	localparam logic [7:0] TrailHiF4  = 8'h8F;

	localparam logic [7:0] Lead2Lo = 8'hC2;
	localparam logic [7:0] Lead2Hi = 8'hDF;
	localparam logic [7:0] Lead3Lo = 8'hE0;
	localparam logic [7:0] Lead3Hi = 8'hEF;
	localparam logic [7:0] Lead4Lo = 8'hF0;
	localparam logic [7:0] Lead4Hi = 8'hF4;

	// results caused by one input byte: up to four data bytes, then an optional end marker
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n_data;
		logic            eos;
		logic            ign;
		logic            inv;
	} uics_group_t;

	function automatic logic in_rng(input logic [CpW-1:0] cp, input logic [CpW-1:0] lo,
			input logic [CpW-1:0] hi);
		return (cp >= lo) && (cp <= hi);
	endfunction

	function automatic logic is_ignorable(input logic [CpW-1:0] cp);
		return cp == 21'h000AD || cp == 21'h0034F || cp == 21'h0061C ||
			in_rng(cp, 21'h0115F, 21'h01160) ||
			in_rng(cp, 21'h017B4, 21'h017B5) ||
			in_rng(cp, 21'h0180B, 21'h0180E) ||
			in_rng(cp, 21'h0200B, 21'h0200F) ||
			in_rng(cp, 21'h0202A, 21'h0202E) ||
			in_rng(cp, 21'h02060, 21'h0206F) ||
			cp == 21'h03164 ||
			in_rng(cp, 21'h0FE00, 21'h0FE0F) ||
			cp == 21'h0FEFF || cp == 21'h0FFA0 ||
			in_rng(cp, 21'h0FFF0, 21'h0FFF8) ||
			in_rng(cp, 21'h1BCA0, 21'h1BCA3) ||
			in_rng(cp, 21'h1D173, 21'h1D17A) ||
			in_rng(cp, 21'hE0000, 21'hE0FFF);
	endfunction

endpackage

// ----- hdl/utf8_ignorable_code_point_stripper.sv -----
// Top level: decoder plus a two-group result queue drained one item per transfer.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per transfer and returns the bytes of every well-formed,
// non-ignorable code point, followed by an end marker (m_tuser low, m_tlast high)
// after the byte flagged with s_tlast; the marker carries the ignorable and
// invalid flags for the string. A byte is decoded in the cycle after its transfer,
// while it sits in the input register; its results, if any, are written into the
// result queue as one group once the queue has space, and the master side offers the head.
// The input register takes a byte in every cycle unless it is occupied and the
// two-entry result queue is full; a code point of k bytes yields its k bytes on its
// final byte, so the input takes one byte per cycle while the queue has space, and
// the master side gives out one item per cycle while m_tready is high.
module utf8_ignorable_code_point_stripper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] had_ignorable, [9] had_invalid
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast    // end_of_string
);

	uics_pkg::uics_group_t grp;
	uics_pkg::uics_group_t q_mem_q [2];
	uics_pkg::uics_group_t head;
	logic                  push;
	logic                  pop;
	logic                  space;
	logic [1:0]            count_q;
	logic                  head_q, tail_q;
	logic [2:0]            idx_q;
	logic [2:0]            n_items;
	logic                  is_marker;
	logic                  last_item;
	logic                  fire;

	assign space = count_q != 2'd2;

	uics_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.space    (space),
		.grp      (grp),
		.push     (push)
	);

	assign head      = q_mem_q[head_q];
	assign n_items   = head.n_data + {2'b0, head.eos};
	assign is_marker = idx_q == head.n_data;
	assign last_item = (idx_q + 3'd1) == n_items;
	assign m_tvalid  = count_q != 2'd0;
	assign fire      = m_tvalid && m_tready;
	assign pop       = fire && last_item;

	assign m_tuser = !is_marker;
	assign m_tlast = is_marker;
	assign m_tdata = {6'b0, is_marker && head.inv, is_marker && head.ign,
		is_marker ? 8'h00 : head.bytes[idx_q[1:0]]};

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[tail_q] <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (push) begin
				tail_q <= !tail_q;
			end
			if (fire) begin
				if (last_item) begin
					idx_q  <= '0;
					head_q <= !head_q;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/uics_decode.sv -----
// Input register and UTF-8 decoder state; forms the result group for each byte.
`timescale 1ns / 1ps

module uics_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] in_byte
	input  logic                  s_tlast,   // last_byte
	input  logic                  space,
	output uics_pkg::uics_group_t grp,
	output logic                  push
);

	logic                     v_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic [7:0]               pend_q [3];
	logic [1:0]               held_q, held_d;
	logic [1:0]               exp_q, exp_d;
	logic [uics_pkg::CpW-1:0] acc_q, acc_d, acc_n;
	logic                     seen_ign_q, seen_ign_d;
	logic                     seen_inv_q, seen_inv_d;
	logic                     pend_we;
	logic [1:0]               pend_wi;
	logic                     consumed;
	logic [7:0]               lo, hi;
	logic                     advance;
	logic                     take;

	assign advance  = v_s1 && space;
	assign s_tready = !v_s1 || space;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance && pend_we) begin
			pend_q[pend_wi] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			exp_q      <= '0;
			acc_q      <= '0;
			seen_ign_q <= 1'b0;
			seen_inv_q <= 1'b0;
		end else if (advance) begin
			held_q     <= held_d;
			exp_q      <= exp_d;
			acc_q      <= acc_d;
			seen_ign_q <= seen_ign_d;
			seen_inv_q <= seen_inv_d;
		end
	end

	always_comb begin
		exp_d      = exp_q;
		held_d     = held_q;
		acc_d      = acc_q;
		seen_ign_d = seen_ign_q;
		seen_inv_d = seen_inv_q;
		pend_we    = 1'b0;
		pend_wi    = held_q;
		consumed   = 1'b0;
		acc_n      = {acc_q[uics_pkg::CpW-7:0], byte_s1[5:0]};
		grp        = '0;
		for (int i = 0; i < 4; i++) begin
			grp.bytes[i] = byte_s1;
		end

		// narrow the first trail byte range after leads that would allow bad values
		lo = uics_pkg::TrailLo;
		hi = uics_pkg::TrailHi;
		if (held_q == 2'd1) begin
			unique case (pend_q[0])
				uics_pkg::LeadE0: lo = uics_pkg::TrailLoE0;
				uics_pkg::LeadED: hi = uics_pkg::TrailHiED;
				uics_pkg::LeadF0: lo = uics_pkg::TrailLoF0;
				uics_pkg::LeadF4: hi = uics_pkg::TrailHiF4;
				default: ;
			endcase
		end

		if (exp_q != 2'd0 && held_q != 2'd0) begin
			if (byte_s1 >= lo && byte_s1 <= hi) begin
				consumed = 1'b1;
				if (held_q == exp_q) begin
					if (uics_pkg::is_ignorable(acc_n)) begin
						seen_ign_d = 1'b1;
					end else begin
						grp.n_data = {1'b0, held_q} + 3'd1;
						for (int i = 0; i < 3; i++) begin
							if (2'(i) < held_q) begin
								grp.bytes[i] = pend_q[i];
							end
						end
					end
					exp_d  = '0;
					held_d = '0;
					acc_d  = '0;
				end else begin
					acc_d   = acc_n;
					pend_we = 1'b1;
					held_d  = held_q + 2'd1;
				end
			end else begin
				// drop the held subpart and restart on this byte
				seen_inv_d = 1'b1;
				exp_d      = '0;
				held_d     = '0;
				acc_d      = '0;
			end
		end else begin
			exp_d  = '0;
			held_d = '0;
			acc_d  = '0;
		end

		if (!consumed) begin
			priority if (!byte_s1[7]) begin
				grp.n_data = 3'd1;
			end else if (byte_s1 >= uics_pkg::Lead2Lo && byte_s1 <= uics_pkg::Lead2Hi) begin
				exp_d   = 2'd1;
				acc_d   = {16'b0, byte_s1[4:0]};
				pend_we = 1'b1;
				pend_wi = 2'd0;
				held_d  = 2'd1;
			end else if (byte_s1 >= uics_pkg::Lead3Lo && byte_s1 <= uics_pkg::Lead3Hi) begin
				exp_d   = 2'd2;
				acc_d   = {17'b0, byte_s1[3:0]};
				pend_we = 1'b1;
				pend_wi = 2'd0;
				held_d  = 2'd1;
			end else if (byte_s1 >= uics_pkg::Lead4Lo && byte_s1 <= uics_pkg::Lead4Hi) begin
				exp_d   = 2'd3;
				acc_d   = {18'b0, byte_s1[2:0]};
				pend_we = 1'b1;
				pend_wi = 2'd0;
				held_d  = 2'd1;
			end else begin
				seen_inv_d = 1'b1;
			end
		end

		if (last_s1) begin
			// an open sequence at the end is truncated
			if (exp_d != 2'd0) begin
				seen_inv_d = 1'b1;
			end
			exp_d      = '0;
			held_d     = '0;
			acc_d      = '0;
			grp.eos    = 1'b1;
			grp.ign    = seen_ign_d;
			grp.inv    = seen_inv_d;
			seen_ign_d = 1'b0;
			seen_inv_d = 1'b0;
		end

		push = advance && (grp.n_data != 3'd0 || grp.eos);
	end

endmodule

// ----- hdl/uics_checker.sv -----
// Port-level checks on the result stream, bound to the top level.
`timescale 1ns / 1ps

module uics_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast != m_tuser))
		else $error("end marker and data flag disagree");

	a_data_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:8] == 8'h00)
		else $error("flags set on a data byte");

	a_marker_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00 && m_tdata[15:10] == 6'b0)
		else $error("end marker carries data");

endmodule

bind utf8_ignorable_code_point_stripper uics_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
